### src/lpms_pkg.sv
package lpms_pkg;

    // Default width of the internal byte position counters.
    localparam int POSITION_BITS_DEFAULT = 32;

    // Configuration port geometry.
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUFFER_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_MESSAGES  = 1'b1;

    // Field widths.
    localparam int BYTE_BITS   = 8;
    localparam int SIZE_BITS   = 16;
    localparam int OFFSET_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int REASON_BITS = 3;

    // System event message: type byte and the end-of-messages code at start+13.
    localparam logic [BYTE_BITS-1:0] EVENT_TYPE        = 8'h53;
    localparam logic [BYTE_BITS-1:0] EVENT_END_CODE    = 8'h43;
    localparam int                   EVENT_CODE_OFFSET = 13;

    // Bytes taken by the size field.
    localparam int SIZE_FIELD_BYTES = 2;

    // Why a scan ended.
    typedef enum logic [REASON_BITS-1:0] {
        STOP_END_OF_BUFFER = 3'd0,
        STOP_ZERO_SIZE     = 3'd1,
        STOP_TRUNCATED     = 3'd2,
        STOP_EVENT         = 3'd3,
        STOP_CAP           = 3'd4
    } t_stop_reason;

    // One result item.
    typedef struct packed {
        logic                   has_record;
        logic [OFFSET_BITS-1:0] msg_offset;
        logic [BYTE_BITS-1:0]   msg_type;
        logic [COUNT_BITS-1:0]  msg_count;
        logic                   is_last;
        t_stop_reason           stop_reason;
    } t_result;

endpackage

### src/length_prefixed_message_scanner.sv
// Scans a buffer of length-prefixed messages (16-bit big-endian size, type byte,
// payload) fed one byte per transfer, and reports each message's start offset,
// type and running count when its type byte arrives. One byte is taken every
// clock unless the result output is stalled; a byte passes an input register
// and the parse logic, and its result is loaded into the result register. The scan ends
// with a final result (is_last set) at the end of the buffer, on a zero or
// oversized size, when max_messages records have been sent, or at a system
// event message whose byte 13 is the end-of-messages code; a stop that comes
// while such an event check is outstanding is reported at the checked byte.
// Bytes after the end are taken and dropped. Any configuration write restarts
// the scan at offset zero; write configuration only while the block is idle.
module length_prefixed_message_scanner #(
    parameter int POSITION_BITS = lpms_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lpms_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lpms_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lpms_pkg::BYTE_BITS-1:0]      i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_has_record,
    output logic [lpms_pkg::OFFSET_BITS-1:0]    o_msg_offset,
    output logic [lpms_pkg::BYTE_BITS-1:0]      o_msg_type,
    output logic [lpms_pkg::COUNT_BITS-1:0]     o_msg_count,
    output logic                                o_is_last,
    output logic [lpms_pkg::REASON_BITS-1:0]    o_stop_reason
);

    logic                           w_byte_valid;
    logic [lpms_pkg::BYTE_BITS-1:0] w_byte;
    logic                           w_out_free;
    logic                           w_fire;
    logic                           w_res_valid;
    lpms_pkg::t_result              w_res;
    lpms_pkg::t_result              w_out_res;

    // A byte is parsed when the result register can take whatever it produces.
    assign w_fire = w_byte_valid && w_out_free;

    lpms_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_data_byte),
        .o_stall (o_in_stall),
        .i_fire  (w_fire),
        .o_valid (w_byte_valid),
        .o_data  (w_byte)
    );

    lpms_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_byte      (w_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lpms_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    // Result fields to ports.
    assign o_has_record  = w_out_res.has_record;
    assign o_msg_offset  = w_out_res.msg_offset;
    assign o_msg_type    = w_out_res.msg_type;
    assign o_msg_count   = w_out_res.msg_count;
    assign o_is_last     = w_out_res.is_last;
    assign o_stop_reason = w_out_res.stop_reason;

    // A result is produced only when the result register has room for it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_fire && (!o_out_valid || !i_out_stall)))
        else $error("result produced while the result register is occupied");

    // A result without a record always ends the scan.
    a_stop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_record) |-> o_is_last)
        else $error("result without a record is not marked last");

    // Only the final result carries a stop reason.
    a_reason_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_last) |-> (o_stop_reason == lpms_pkg::STOP_END_OF_BUFFER))
        else $error("stop reason set on a result that is not last");

endmodule

### src/lpms_in_reg.sv
module lpms_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [lpms_pkg::BYTE_BITS-1:0] i_data,
    output logic                           o_stall,
    input  logic                           i_fire,
    output logic                           o_valid,
    output logic [lpms_pkg::BYTE_BITS-1:0] o_data
);

    logic                           r_valid;
    logic [lpms_pkg::BYTE_BITS-1:0] r_data;
    logic                           w_load;

    // The register is free when empty or when its byte is consumed this cycle.
    assign o_stall = r_valid && !i_fire;
    assign w_load  = i_valid && !o_stall;

    // Occupancy of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    // Captured byte.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/lpms_core.sv
module lpms_core #(
    parameter int POSITION_BITS = lpms_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lpms_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lpms_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_fire,
    input  logic [lpms_pkg::BYTE_BITS-1:0]      i_byte,
    output logic                                o_res_valid,
    output lpms_pkg::t_result                   o_res
);

    // Compare width: holds a position or a length plus a carry and a sign.
    localparam int CW = ((POSITION_BITS > lpms_pkg::CFG_DATA_BITS) ?
                         POSITION_BITS : lpms_pkg::CFG_DATA_BITS) + 2;

    typedef enum logic [1:0] {
        PH_SIZE_HI,
        PH_SIZE_LO,
        PH_TYPE,
        PH_PAYLOAD
    } t_phase;

    logic [lpms_pkg::CFG_DATA_BITS-1:0] r_buf_len;
    logic [lpms_pkg::CFG_DATA_BITS-1:0] r_max_msgs;

    logic [POSITION_BITS-1:0]        r_pos,        n_pos;
    t_phase                          r_phase,      n_phase;
    logic [lpms_pkg::SIZE_BITS-1:0]  r_size,       n_size;
    logic [lpms_pkg::SIZE_BITS-1:0]  r_remain,     n_remain;
    logic [POSITION_BITS-1:0]        r_start,      n_start;
    logic [lpms_pkg::COUNT_BITS-1:0] r_count,      n_count;
    logic [POSITION_BITS-1:0]        r_chk_pos,    n_chk_pos;
    logic                            r_chk_pend,   n_chk_pend;
    logic                            r_done,       n_done;
    logic                            r_deferred,   n_deferred;
    lpms_pkg::t_stop_reason          r_def_reason, n_def_reason;

    // True when a 3-byte header starting at s lies inside the buffer.
    function automatic logic header_fits(input logic [POSITION_BITS-1:0] s,
                                         input logic [lpms_pkg::CFG_DATA_BITS-1:0] len);
        header_fits = (len > lpms_pkg::CFG_DATA_BITS'(2)) &&
                      (CW'(s) < (CW'(len) - CW'(2)));
    endfunction

    // A result that ends the scan without a record.
    function automatic lpms_pkg::t_result stop_result(
        input logic [lpms_pkg::COUNT_BITS-1:0] count,
        input lpms_pkg::t_stop_reason          reason);
        lpms_pkg::t_result res;
        res             = '0;
        res.msg_count   = count;
        res.is_last     = 1'b1;
        res.stop_reason = reason;
        stop_result     = res;
    endfunction

    // Next state and result for the byte in the input register.
    always_comb begin
        logic                            chk_hit;
        logic                            pend;
        logic                            arm;
        logic                            stop;
        lpms_pkg::t_stop_reason          reason;
        logic [lpms_pkg::SIZE_BITS-1:0]  size_full;
        logic [lpms_pkg::SIZE_BITS:0]    need;
        logic [lpms_pkg::COUNT_BITS-1:0] cnt_inc;
        logic [POSITION_BITS-1:0]        next_start;

        n_pos        = r_pos;
        n_phase      = r_phase;
        n_size       = r_size;
        n_remain     = r_remain;
        n_start      = r_start;
        n_count      = r_count;
        n_chk_pos    = r_chk_pos;
        n_chk_pend   = r_chk_pend;
        n_done       = r_done;
        n_deferred   = r_deferred;
        n_def_reason = r_def_reason;
        o_res_valid  = 1'b0;
        o_res        = '0;

        chk_hit    = r_chk_pend && (r_pos == r_chk_pos);
        pend       = r_chk_pend && !chk_hit;
        size_full  = {r_size[lpms_pkg::SIZE_BITS-1:lpms_pkg::BYTE_BITS], i_byte};
        need       = {1'b0, size_full} + (lpms_pkg::SIZE_BITS+1)'(lpms_pkg::SIZE_FIELD_BYTES);
        cnt_inc    = r_count + lpms_pkg::COUNT_BITS'(1);
        next_start = r_start + POSITION_BITS'(lpms_pkg::SIZE_FIELD_BYTES)
                   + POSITION_BITS'(r_size);
        arm        = (i_byte == lpms_pkg::EVENT_TYPE) && !pend &&
                     (r_buf_len > lpms_pkg::CFG_DATA_BITS'(lpms_pkg::EVENT_CODE_OFFSET)) &&
                     (CW'(r_start) < (CW'(r_buf_len) - CW'(lpms_pkg::EVENT_CODE_OFFSET)));
        stop       = 1'b0;
        reason     = lpms_pkg::STOP_END_OF_BUFFER;

        if (i_fire && !r_done) begin
            n_pos = r_pos + POSITION_BITS'(1);
            if (chk_hit) begin
                n_chk_pend = 1'b0;
            end

            if (chk_hit && (i_byte == lpms_pkg::EVENT_END_CODE)) begin
                // End-of-messages code found at the armed position.
                n_done      = 1'b1;
                o_res_valid = 1'b1;
                o_res       = stop_result(r_count, lpms_pkg::STOP_EVENT);
            end else if (chk_hit && r_deferred) begin
                // The check failed; the stop that waited on it now takes effect.
                n_done      = 1'b1;
                o_res_valid = 1'b1;
                o_res       = stop_result(r_count, r_def_reason);
            end else if (!r_deferred) begin
                case (r_phase)
                    PH_SIZE_HI: begin
                        if (!header_fits(r_start, r_buf_len)) begin
                            n_done      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = stop_result(r_count, lpms_pkg::STOP_END_OF_BUFFER);
                        end else if (r_count >= r_max_msgs) begin
                            n_done      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = stop_result(r_count, lpms_pkg::STOP_CAP);
                        end else begin
                            n_size  = {i_byte, lpms_pkg::BYTE_BITS'(0)};
                            n_phase = PH_SIZE_LO;
                        end
                    end
                    PH_SIZE_LO: begin
                        n_size = size_full;
                        if (size_full == '0) begin
                            n_done      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = stop_result(r_count, lpms_pkg::STOP_ZERO_SIZE);
                        end else if (!((CW'(r_buf_len) >= CW'(need)) &&
                                       (CW'(r_start) <= (CW'(r_buf_len) - CW'(need))))) begin
                            n_done      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res       = stop_result(r_count, lpms_pkg::STOP_TRUNCATED);
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        // Type byte: emit the record and set up the next message.
                        n_count = cnt_inc;
                        if (arm) begin
                            n_chk_pend = 1'b1;
                            n_chk_pos  = r_start + POSITION_BITS'(lpms_pkg::EVENT_CODE_OFFSET);
                        end
                        n_start  = next_start;
                        n_remain = r_size - lpms_pkg::SIZE_BITS'(1);
                        n_phase  = (r_size != lpms_pkg::SIZE_BITS'(1)) ? PH_PAYLOAD : PH_SIZE_HI;

                        if (!header_fits(next_start, r_buf_len)) begin
                            stop   = 1'b1;
                            reason = lpms_pkg::STOP_END_OF_BUFFER;
                        end else if (cnt_inc >= r_max_msgs) begin
                            stop   = 1'b1;
                            reason = lpms_pkg::STOP_CAP;
                        end

                        o_res_valid      = 1'b1;
                        o_res.has_record = 1'b1;
                        o_res.msg_offset = lpms_pkg::OFFSET_BITS'(r_start);
                        o_res.msg_type   = i_byte;
                        o_res.msg_count  = cnt_inc;

                        if (stop) begin
                            if (pend || arm) begin
                                // An event check is outstanding: hold the stop until it resolves.
                                n_deferred   = 1'b1;
                                n_def_reason = reason;
                            end else begin
                                n_done            = 1'b1;
                                o_res.is_last     = 1'b1;
                                o_res.stop_reason = reason;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_remain = r_remain - lpms_pkg::SIZE_BITS'(1);
                        if (r_remain == lpms_pkg::SIZE_BITS'(1)) begin
                            n_phase = PH_SIZE_HI;
                        end
                    end
                    default: begin
                        n_phase = PH_SIZE_HI;
                    end
                endcase
            end
        end
    end

    // Configuration registers and scan state; a configuration write restarts the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            if (!i_rst_n) begin
                r_buf_len  <= '0;
                r_max_msgs <= '0;
            end else begin
                case (i_cfg_index)
                    lpms_pkg::CFG_BUFFER_LENGTH: begin
                        r_buf_len <= i_cfg_data;
                    end
                    lpms_pkg::CFG_MAX_MESSAGES: begin
                        r_max_msgs <= i_cfg_data;
                    end
                    default: begin
                        r_buf_len <= r_buf_len;
                    end
                endcase
            end
            r_pos        <= '0;
            r_phase      <= PH_SIZE_HI;
            r_size       <= '0;
            r_remain     <= '0;
            r_start      <= '0;
            r_count      <= '0;
            r_chk_pos    <= '0;
            r_chk_pend   <= 1'b0;
            r_done       <= 1'b0;
            r_deferred   <= 1'b0;
            r_def_reason <= lpms_pkg::STOP_END_OF_BUFFER;
        end else begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_size       <= n_size;
            r_remain     <= n_remain;
            r_start      <= n_start;
            r_count      <= n_count;
            r_chk_pos    <= n_chk_pos;
            r_chk_pend   <= n_chk_pend;
            r_done       <= n_done;
            r_deferred   <= n_deferred;
            r_def_reason <= n_def_reason;
        end
    end

endmodule

### src/lpms_out_reg.sv
module lpms_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpms_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output lpms_pkg::t_result o_res
);

    logic              r_valid;
    lpms_pkg::t_result r_res;

    // A new result may enter when the register is empty or drains this cycle.
    assign o_free = !r_valid || !i_stall;

    // Occupancy of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Held result.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
